FILE: design/gfpr_pkg.sv
// Shared constants and types for the gap-framed packet receiver.
package gfpr_pkg;

  localparam int          PACKET_BYTES_DEF = 16;
  localparam logic [7:0]  GAP_LIMIT_RST    = 8'd2;
  localparam logic [7:0]  IDLE_MAX         = 8'd255;
  localparam logic        ACT_TICK         = 1'b0;
  localparam logic        ACT_BYTE         = 1'b1;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_SHOW
  } gfpr_em_state_t;

  // Hand-off of a completed packet from the control to the emitter.
  typedef struct packed {
    logic start;
    logic half;
  } gfpr_start_t;

endpackage

FILE: design/gfpr_if.sv
// Channel interfaces: input events, result bytes and configuration writes.
interface gfpr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic       overrun_error;
  logic       framing_error;
  modport source (output valid, action, rx_byte, overrun_error, framing_error, input ready);
  modport sink   (input valid, action, rx_byte, overrun_error, framing_error, output ready);
endinterface

interface gfpr_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] byte_index;
  logic [7:0] packet_byte;
  logic       buffer_half;
  logic       last;
  modport source (output valid, byte_index, packet_byte, buffer_half, last, input ready);
  modport sink   (input valid, byte_index, packet_byte, buffer_half, last, output ready);
endinterface

interface gfpr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: design/gap_framed_packet_receiver_unit.sv
// Top level of the gap-framed packet receiver.
// After a packet's final byte is taken, the emitter steps through its read state and then its output state, where
// the first byte is offered. Input ticks and bytes are taken whenever no packet is being emitted; each emitted byte
// is a memory read, then the output stage, which holds the byte until the result channel takes it.
// No input transaction is taken while a packet is being emitted.
// Reset clears the timer, frame state and count, loads gap_limit 2 and half 1; the store keeps its contents.
module gap_framed_packet_receiver_unit
  import gfpr_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gfpr_in_if.sink     in_if,
  gfpr_out_if.source  out_if,
  gfpr_cfg_if.sink    cfg_if
);

  localparam int IDX_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;

  logic             busy;
  logic             mem_we;
  logic [IDX_W:0]   mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [IDX_W:0]   mem_raddr;
  logic [7:0]       mem_rdata;
  gfpr_start_t      start;

  gfpr_ctrl #(.PACKET_BYTES(PACKET_BYTES), .IDX_W(IDX_W)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_if    (cfg_if),
    .busy      (busy),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .start     (start)
  );

  gfpr_mem #(.IDX_W(IDX_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gfpr_emit #(.PACKET_BYTES(PACKET_BYTES), .IDX_W(IDX_W)) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_if    (out_if)
  );

endmodule

FILE: design/gfpr_mem.sv
// Double-buffered packet store: one write port, one registered read port.
module gfpr_mem
  import gfpr_pkg::*;
#(
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W:0]   waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [IDX_W:0]   raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [2**(IDX_W+1)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/gfpr_ctrl.sv
// Frame tracking: idle timer, frame validity, byte count and buffer half.
module gfpr_ctrl
  import gfpr_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int IDX_W        = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  gfpr_in_if.sink         in_if,
  gfpr_cfg_if.sink        cfg_if,
  input  logic            busy,
  output logic            mem_we,
  output logic [IDX_W:0]  mem_waddr,
  output logic [7:0]      mem_wdata,
  output gfpr_start_t     start
);

  logic [7:0]       gap_r, gap_nxt;
  logic [7:0]       idle_r, idle_nxt;
  logic             fv_r, fv_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             half_r, half_nxt;

  logic             acc;
  logic             new_frame;
  logic             fv_t;
  logic [IDX_W-1:0] cnt_t;
  logic [IDX_W-1:0] slot;
  logic             slot_ok;
  logic             pkt_done;

  assign in_if.ready  = !busy;
  assign cfg_if.ready = 1'b1;
  assign acc          = in_if.valid && in_if.ready;

  assign new_frame = idle_r > gap_r;
  assign fv_t      = new_frame ? 1'b1 : fv_r;
  assign cnt_t     = new_frame ? '0 : cnt_r;
  assign slot      = cnt_t ^ IDX_W'(1);
  // Odd packet sizes: the swapped index of the final byte falls beyond the packet, so that byte is not stored.
  assign slot_ok   = {1'b0, slot} < (IDX_W+1)'(PACKET_BYTES);
  assign pkt_done  = cnt_t == IDX_W'(PACKET_BYTES - 1);

  assign mem_waddr = {half_r, slot};
  assign mem_wdata = in_if.rx_byte;

  always_comb begin
    gap_nxt     = cfg_if.valid ? cfg_if.data : gap_r;
    idle_nxt    = idle_r;
    fv_nxt      = fv_r;
    cnt_nxt     = cnt_r;
    half_nxt    = half_r;
    mem_we      = 1'b0;
    start.start = 1'b0;
    start.half  = half_r;
    if (acc) begin
      if (in_if.action == ACT_TICK) begin
        if (idle_r != IDLE_MAX) begin
          idle_nxt = idle_r + 8'd1;
        end
      end else begin
        idle_nxt = '0;
        if (in_if.overrun_error) begin
          // Abort the frame and drop the byte.
          fv_nxt  = 1'b0;
          cnt_nxt = '0;
        end else begin
          fv_nxt = fv_t && !in_if.framing_error;
          mem_we = slot_ok;
          if (pkt_done) begin
            cnt_nxt = '0;
            if (fv_nxt) begin
              start.start = 1'b1;
              half_nxt    = !half_r;
            end
          end else begin
            cnt_nxt = cnt_t + IDX_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r  <= GAP_LIMIT_RST;
      idle_r <= '0;
      fv_r   <= 1'b0;
      cnt_r  <= '0;
      half_r <= 1'b1;
    end else begin
      gap_r  <= gap_nxt;
      idle_r <= idle_nxt;
      fv_r   <= fv_nxt;
      cnt_r  <= cnt_nxt;
      half_r <= half_nxt;
    end
  end

  a_idle_sat: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_if.action == ACT_TICK && idle_r == IDLE_MAX |=> idle_r == IDLE_MAX)
    else $error("idle timer left saturation on a tick");

  a_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    start.start |=> half_r != $past(half_r))
    else $error("buffer half did not toggle on packet completion");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} < (IDX_W+1)'(PACKET_BYTES))
    else $error("byte count out of range");

endmodule

FILE: design/gfpr_emit.sv
// Packet emitter: reads the completed half byte by byte into the result channel.
module gfpr_emit
  import gfpr_pkg::*;
#(
  parameter int PACKET_BYTES = PACKET_BYTES_DEF,
  parameter int IDX_W        = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  gfpr_start_t     start,
  output logic            busy,
  output logic            mem_re,
  output logic [IDX_W:0]  mem_raddr,
  input  logic [7:0]      mem_rdata,
  gfpr_out_if.source      out_if
);

  gfpr_em_state_t   state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             half_r, half_nxt;
  logic             is_last;

  assign is_last = idx_r == IDX_W'(PACKET_BYTES - 1);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    half_nxt  = half_r;
    unique case (state_r)
      EM_IDLE: begin
        if (start.start) begin
          state_nxt = EM_READ;
          idx_nxt   = '0;
          half_nxt  = start.half;
        end
      end
      EM_READ: state_nxt = EM_SHOW;
      EM_SHOW: begin
        if (out_if.ready) begin
          if (is_last) begin
            state_nxt = EM_IDLE;
          end else begin
            state_nxt = EM_READ;
            idx_nxt   = idx_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = EM_IDLE;
    endcase
  end

  always_comb begin
    busy               = state_r != EM_IDLE;
    mem_re             = state_r == EM_READ;
    mem_raddr          = {half_r, idx_r};
    out_if.valid       = state_r == EM_SHOW;
    out_if.byte_index  = 4'(idx_r);
    out_if.packet_byte = mem_rdata;
    out_if.buffer_half = half_r;
    out_if.last        = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      idx_r   <= '0;
      half_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      half_r  <= half_nxt;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start.start |=> state_r == EM_READ && idx_r == '0)
    else $error("emitter missed a packet start");

  a_read_show: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == EM_READ |=> state_r == EM_SHOW)
    else $error("read not followed by result");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start.start |-> state_r == EM_IDLE)
    else $error("packet started while emitting");

endmodule
